// ===== design/swvm_pkg.sv =====
// ----------------------------------------------------------------------------
// swvm_pkg: shared types and constants of the stopwatch / voltmeter display
// Widths, action and register codes, division constants and the segment
// decode used by the stopwatch / voltmeter display block.
// ----------------------------------------------------------------------------
package swvm_pkg;

   localparam int ADC_BITS_DEFAULT = 12;
   localparam int DIGIT_COUNT      = 4;

   localparam int ACTION_W  = 2;
   localparam int SAMPLE_W  = 12;
   localparam int TPS_W     = 16;
   localparam int FS_W      = 10;
   localparam int CSR_W     = 16;
   localparam int ELAPSED_W = 13;
   localparam int SEG_W     = 8;
   localparam int POS_W     = 2;
   localparam int ENABLE_W  = DIGIT_COUNT;
   localparam int MIN_W     = 7;
   localparam int SEC_W     = 6;
   localparam int VOLT_W    = 10;
   localparam int DIGIT_W   = 4;
   localparam int QEST_W    = 11;

   localparam logic [ACTION_W-1:0] ACTION_TICK       = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_START_STOP = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_MODE       = 2'd2;

   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_FULL_SCALE       = 1'b1;

   localparam logic [TPS_W-1:0]     TPS_RESET    = 16'd1000;
   localparam logic [FS_W-1:0]      FS_RESET     = 10'd330;
   localparam logic [ELAPSED_W-1:0] SECONDS_LAST = 13'd5999;

   // Reciprocal multipliers: x/60 = (x*17477)>>20 for x < 6000,
   // x/10 = (x*205)>>11 for x < 1029, x/100 = (x*41)>>12 for x < 1024.
   localparam logic [14:0] RECIP_60  = 15'd17477;
   localparam logic [7:0]  RECIP_10  = 8'd205;
   localparam logic [5:0]  RECIP_100 = 6'd41;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [POS_W-1:0]     pos;
      logic                 voltage_mode;
      logic [ELAPSED_W-1:0] elapsed;
   } swvm_item_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      unique case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

// ===== design/swvm_digit_pipe.sv =====
// ----------------------------------------------------------------------------
// swvm_digit_pipe: digit formation pipeline
// Scales the sample to centivolts, splits seconds into mm:ss, picks the shown
// digit and drives the registered result channel.
// ----------------------------------------------------------------------------
module swvm_digit_pipe #(
   parameter int ADC_BITS = swvm_pkg::ADC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  swvm_pkg::swvm_item_type     in_item,
   input  logic [ADC_BITS-1:0]         in_sample,
   input  logic [swvm_pkg::FS_W-1:0]   full_scale,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [swvm_pkg::SEG_W-1:0]    rsp_segment_pattern,
   output logic [swvm_pkg::ENABLE_W-1:0] rsp_digit_enable,
   output logic [swvm_pkg::POS_W-1:0]    rsp_digit_position
);
   import swvm_pkg::*;

   localparam int PROD_W = ADC_BITS + FS_W;
   localparam int ADC_MAX = (1 << ADC_BITS) - 1;
   localparam logic [PROD_W:0] MAX_1 = (PROD_W + 1)'(ADC_MAX);
   localparam logic [PROD_W:0] MAX_2 = (PROD_W + 1)'(2 * ADC_MAX);

   logic rdy2, rdy3, rdy4, rdy_rsp;
   logic v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic v2_in, v3_in, v4_in, rsp_valid_in;

   swvm_item_type item2_ff, item3_ff, item4_ff;
   logic [PROD_W-1:0] prod2_ff, prod3_ff;
   logic [MIN_W-1:0]  mins2_ff, mins3_ff, mins4_ff;
   logic [QEST_W-1:0] qest3_ff;
   logic [SEC_W-1:0]  secs3_ff, secs4_ff;
   logic [VOLT_W-1:0] volt4_ff;
   logic [SEG_W-1:0]    seg_ff;
   logic [ENABLE_W-1:0] enable_ff;
   logic [POS_W-1:0]    pos_ff;

   logic [PROD_W-1:0] prod2_in;
   logic [27:0]       mins_prod;
   logic [MIN_W-1:0]  mins2_in;
   logic [PROD_W:0]   qsum;
   logic [QEST_W-1:0] qest3_in;
   logic [12:0]       mins_x60;
   logic [SEC_W-1:0]  secs3_in;
   logic [PROD_W:0]   qm, rem;
   logic [VOLT_W-1:0] volt4_in;
   logic [17:0]       v10_prod, s10_prod, m10_prod;
   logic [15:0]       v100_prod;
   logic [6:0]        v10;
   logic [3:0]        v100, s10, m10;
   logic [DIGIT_W-1:0] digit;
   logic [SEG_W-1:0]    seg_in;
   logic [ENABLE_W-1:0] enable_in;

   assign rdy_rsp  = !rsp_valid_ff || !rsp_stall;
   assign rdy4     = !v4_ff || rdy_rsp;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_stall = !rdy2;

   assign v2_in        = rdy2 ? in_valid : v2_ff;
   assign v3_in        = rdy3 ? v2_ff : v3_ff;
   assign v4_in        = rdy4 ? v3_ff : v4_ff;
   assign rsp_valid_in = rdy_rsp ? v4_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multiply stage.
   always_comb begin
      prod2_in  = PROD_W'(in_sample) * PROD_W'(full_scale);
      mins_prod = 28'(in_item.elapsed) * 28'(RECIP_60);
      mins2_in  = mins_prod[20 +: MIN_W];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         item2_ff <= in_item;
         prod2_ff <= prod2_in;
         mins2_ff <= mins2_in;
      end
   end

   // Quotient estimate and seconds remainder.
   always_comb begin
      qsum     = (PROD_W + 1)'(prod2_ff) + (PROD_W + 1)'(prod2_ff >> ADC_BITS);
      qest3_in = QEST_W'(qsum >> ADC_BITS);
      mins_x60 = (13'(mins2_ff) << 6) - (13'(mins2_ff) << 2);
      secs3_in = SEC_W'(item2_ff.elapsed - mins_x60);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         item3_ff <= item2_ff;
         prod3_ff <= prod2_ff;
         qest3_ff <= qest3_in;
         mins3_ff <= mins2_ff;
         secs3_ff <= secs3_in;
      end
   end

   // The estimate is low by at most two; the remainder settles it.
   always_comb begin
      qm  = {qest3_ff, {ADC_BITS{1'b0}}} - (PROD_W + 1)'(qest3_ff);
      rem = (PROD_W + 1)'(prod3_ff) - qm;
      priority if (rem >= MAX_2) begin
         volt4_in = VOLT_W'(qest3_ff + QEST_W'(2));
      end else if (rem >= MAX_1) begin
         volt4_in = VOLT_W'(qest3_ff + QEST_W'(1));
      end else begin
         volt4_in = VOLT_W'(qest3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         item4_ff <= item3_ff;
         volt4_ff <= volt4_in;
         mins4_ff <= mins3_ff;
         secs4_ff <= secs3_ff;
      end
   end

   // Digit split and segment decode.
   always_comb begin
      v10_prod  = 18'(volt4_ff) * 18'(RECIP_10);
      v100_prod = 16'(volt4_ff) * 16'(RECIP_100);
      s10_prod  = 18'(secs4_ff) * 18'(RECIP_10);
      m10_prod  = 18'(mins4_ff) * 18'(RECIP_10);
      v10       = v10_prod[17:11];
      v100      = v100_prod[15:12];
      s10       = s10_prod[14:11];
      m10       = m10_prod[14:11];
      if (item4_ff.voltage_mode) begin
         unique case (item4_ff.pos)
            2'd0:    digit = DIGIT_W'(volt4_ff - 10'(v10) * 10'd10);
            2'd1:    digit = DIGIT_W'(v10 - 7'(v100) * 7'd10);
            2'd2:    digit = (v100 == 4'd10) ? 4'd0 : v100;
            default: digit = 4'd0;
         endcase
      end else begin
         unique case (item4_ff.pos)
            2'd0:    digit = DIGIT_W'(secs4_ff - 6'(s10) * 6'd10);
            2'd1:    digit = s10;
            2'd2:    digit = DIGIT_W'(mins4_ff - 7'(m10) * 7'd10);
            default: digit = m10;
         endcase
      end
      seg_in    = seg_of(digit);
      enable_in = ENABLE_W'(4'b1000 >> item4_ff.pos);
   end

   always_ff @(posedge clock) begin
      if (rdy_rsp) begin
         seg_ff    <= seg_in;
         enable_ff <= enable_in;
         pos_ff    <= item4_ff.pos;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_segment_pattern = seg_ff;
   assign rsp_digit_enable    = enable_ff;
   assign rsp_digit_position  = pos_ff;

endmodule

// ===== design/stopwatch_voltmeter_seven_segment_mux.sv =====
// ----------------------------------------------------------------------------
// stopwatch_voltmeter_seven_segment_mux: multiplexed four-digit display
// Stopwatch and voltmeter shown one digit per refresh tick on a four-digit
// common-anode seven-segment display.
//
// The req channel carries one event per beat: a refresh tick, a start/stop
// press or a display mode press, with the converter sample. Presses only
// change state and give no result. Each refresh tick gives one rsp beat:
// the active-low segment byte, the one-hot digit enable and the position.
// A new event is accepted in every cycle while req_stall is low, and each
// tick's result is registered through the five-register digit pipeline
// (input register, multiply, quotient estimate, correction, result).
// The csr port writes ticks per second (index 0) and full-scale centivolts
// (index 1); the user must write while the block is idle, which it does not enforce.
// Reset stops the stopwatch, clears seconds, tick count and digit pointer,
// selects stopwatch display and loads 1000 and 330 into the registers.
// When rsp_stall holds the result, the stages behind it keep filling, and
// req_stall rises only once every stage holds a beat.
// ----------------------------------------------------------------------------
module stopwatch_voltmeter_seven_segment_mux #(
   parameter int ADC_BITS = swvm_pkg::ADC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [swvm_pkg::ACTION_W-1:0]    req_action,
   input  logic [swvm_pkg::SAMPLE_W-1:0]    req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [swvm_pkg::SEG_W-1:0]       rsp_segment_pattern,
   output logic [swvm_pkg::ENABLE_W-1:0]    rsp_digit_enable,
   output logic [swvm_pkg::POS_W-1:0]       rsp_digit_position,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [swvm_pkg::CSR_W-1:0]       csr_wdata
);
   import swvm_pkg::*;

   logic                 running_ff, running_in;
   logic                 mode_ff, mode_in;
   logic [TPS_W-1:0]     tick_ff, tick_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]     pointer_ff, pointer_in;
   logic [TPS_W-1:0]     tps_ff;
   logic [FS_W-1:0]      fs_ff;
   logic                 s1_valid_ff, s1_valid_in;
   swvm_item_type        s1_item_ff, s1_item_in;
   logic [ADC_BITS-1:0]  s1_sample_ff;

   logic                 pipe_stall;
   logic                 s1_ready;
   logic                 accept;
   logic                 is_tick;
   logic [TPS_W-1:0]     tick_inc;

   assign s1_ready  = !s1_valid_ff || !pipe_stall;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign is_tick   = (req_action == ACTION_TICK);
   assign tick_inc  = tick_ff + TPS_W'(1);

   always_comb begin
      running_in = running_ff;
      mode_in    = mode_ff;
      tick_in    = tick_ff;
      elapsed_in = elapsed_ff;
      pointer_in = pointer_ff;
      if (accept) begin
         priority if (req_action == ACTION_START_STOP) begin
            running_in = !running_ff;
            tick_in    = '0;
            elapsed_in = '0;
         end else if (req_action == ACTION_MODE) begin
            mode_in = !mode_ff;
         end else if (is_tick) begin
            if (running_ff) begin
               if (tick_inc >= tps_ff) begin
                  tick_in    = '0;
                  elapsed_in = (elapsed_ff == SECONDS_LAST) ? '0
                                                            : elapsed_ff + ELAPSED_W'(1);
               end else begin
                  tick_in = tick_inc;
               end
            end
            pointer_in = pointer_ff + POS_W'(1);
         end else begin
            // The unused action code leaves the state alone.
         end
      end
      s1_item_in.pos          = pointer_ff;
      s1_item_in.voltage_mode = mode_ff;
      s1_item_in.elapsed      = elapsed_in;
      s1_valid_in = s1_ready ? (accept && is_tick) : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         mode_ff     <= 1'b0;
         tick_ff     <= '0;
         elapsed_ff  <= '0;
         pointer_ff  <= '0;
         s1_valid_ff <= 1'b0;
         tps_ff      <= TPS_RESET;
         fs_ff       <= FS_RESET;
      end else begin
         running_ff  <= running_in;
         mode_ff     <= mode_in;
         tick_ff     <= tick_in;
         elapsed_ff  <= elapsed_in;
         pointer_ff  <= pointer_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TICKS_PER_SECOND: tps_ff <= csr_wdata;
               CSR_FULL_SCALE:       fs_ff  <= FS_W'(csr_wdata);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_item_ff   <= s1_item_in;
         s1_sample_ff <= ADC_BITS'(req_adc_sample);
      end
   end

   swvm_digit_pipe #(
      .ADC_BITS (ADC_BITS)
   ) u_digit_pipe (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (s1_valid_ff),
      .in_stall            (pipe_stall),
      .in_item             (s1_item_ff),
      .in_sample           (s1_sample_ff),
      .full_scale          (fs_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_enable    (rsp_digit_enable),
      .rsp_digit_position  (rsp_digit_position)
   );

   a_enable_matches_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_enable == ENABLE_W'(4'b1000 >> rsp_digit_position))
      else $error("digit enable does not match digit position");

   a_seconds_in_range: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff <= SECONDS_LAST)
      else $error("elapsed seconds beyond wrap point");

   a_start_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACTION_START_STOP |=> elapsed_ff == '0 && tick_ff == '0)
      else $error("start/stop press did not clear the stopwatch");

   a_pointer_advances: assert property (@(posedge clock) disable iff (reset)
      accept && is_tick |=> pointer_ff == $past(pointer_ff) + POS_W'(1))
      else $error("digit pointer did not advance on a refresh tick");

endmodule
